// ===== rtl/core/vigenere_byte_cipher_assert.svh =====
// Assertion macros for the port-level checker module of the byte cipher.
`ifndef VIGENERE_BYTE_CIPHER_ASSERT_SVH
`define VIGENERE_BYTE_CIPHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VBC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("vigenere_byte_cipher assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define VBC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("vigenere_byte_cipher assertion failed");

`endif

// ===== rtl/core/vbc_pkg.sv =====
// Shared types, codes and constants of the byte cipher.
package vbc_pkg;

  localparam int ALPHABET_DEPTH_DEF = 64;
  localparam int KEY_DEPTH_DEF      = 64;
  localparam int FIFO_DEPTH         = 4;
  localparam int WIDE_IDX_W         = 9;
  localparam int RESET_LETTERS      = 26;
  localparam logic [7:0] LETTER_A   = 8'h41;

  typedef enum logic [1:0] {
    OP_ALPHA  = 2'd0,
    OP_KEY    = 2'd1,
    OP_CIPHER = 2'd2
  } vbc_op_t;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_ALEN = 2'd1,
    CFG_KLEN = 2'd2
  } vbc_cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_PICK,
    BK_LOOK,
    BK_SEND
  } vbc_bk_state_t;

  // One queued transaction for the back end.
  typedef struct packed {
    logic       is_cipher;
    logic [5:0] idx;
    logic [7:0] val;
    logic [7:0] kb;
  } vbc_item_t;

  // Back-end control strobes, decoded per state.
  typedef struct packed {
    logic pop;
    logic wr_en;
    logic ld_match;
    logic ld_scan;
    logic ld_pick;
    logic rd_en;
    logic ld_out;
  } vbc_bk_ctl_t;

  // Alphabet content after reset: A..Z, then zeros.
  function automatic logic [7:0] reset_letter(input logic [7:0] i);
    logic [7:0] r;
    if (i < 8'(RESET_LETTERS)) r = LETTER_A + i;
    else                       r = 8'h00;
    return r;
  endfunction

endpackage

// ===== rtl/core/vbc_fifo.sv =====
// Short in-order queue between the front end and the back end.
module vbc_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  vbc_pkg::vbc_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output vbc_pkg::vbc_item_t head
);
  import vbc_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  vbc_item_t       mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  assign full       = (cnt_r == CW'(FIFO_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== rtl/core/vbc_front.sv =====
// Front end: accepts transactions, owns the key store and the key position.
module vbc_front #(
  parameter int KEY_DEPTH = vbc_pkg::KEY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vbc_pkg::vbc_op_t   op,
  input  logic [5:0]         idx,
  input  logic [7:0]         val,
  input  logic               restart,
  input  logic [6:0]         klen,
  input  logic               q_full,
  output logic               q_push,
  output vbc_pkg::vbc_item_t q_item
);
  import vbc_pkg::*;

  localparam int KW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KLW = $clog2(KEY_DEPTH + 1);
  localparam int KCW = (KLW + 1 > 7) ? KLW + 1 : 7;

  logic [7:0]      key_mem [KEY_DEPTH];
  logic [7:0]      key_rd_r;
  logic [7:0]      msg_r;
  logic            pend_r;
  logic [KW-1:0]   pos_r;
  logic [KW-1:0]   pos_nxt;
  logic [KW-1:0]   pos_base;
  logic [KCW-1:0]  klen_eff;
  logic            accept;
  logic            is_alpha;
  logic            is_key;
  logic            is_cipher;
  logic [WIDE_IDX_W-1:0] idx_w;
  logic            key_hit;

  assign in_ready = !pend_r && !q_full;
  assign accept   = in_valid && in_ready;
  assign idx_w    = WIDE_IDX_W'(idx);
  assign key_hit  = idx_w < WIDE_IDX_W'(KEY_DEPTH);

  always_comb begin
    is_alpha  = 1'b0;
    is_key    = 1'b0;
    is_cipher = 1'b0;
    unique case (op)
      OP_ALPHA:  is_alpha  = 1'b1;
      OP_KEY:    is_key    = 1'b1;
      OP_CIPHER: is_cipher = 1'b1;
      default:   ;
    endcase
  end

  // Key length clamps to the store depth; a stale position restarts at zero.
  always_comb begin
    logic [KCW-1:0] k;
    logic [KCW-1:0] inc;
    k = KCW'(klen);
    if (k > KCW'(KEY_DEPTH)) klen_eff = KCW'(KEY_DEPTH);
    else                     klen_eff = k;
    if (restart || (KCW'(pos_r) >= klen_eff)) pos_base = '0;
    else                                      pos_base = pos_r;
    inc = KCW'(pos_base) + KCW'(1);
    if (inc >= klen_eff) pos_nxt = '0;
    else                 pos_nxt = inc[KW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && is_key && key_hit) begin
      key_mem[idx_w[KW-1:0]] <= val;
    end
    if (accept && is_cipher) begin
      key_rd_r <= key_mem[pos_base];
      msg_r    <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      pos_r  <= '0;
    end else begin
      pend_r <= accept && is_cipher;
      if (accept && is_cipher) pos_r <= pos_nxt;
    end
  end

  // Alphabet writes go out at once, cipher bytes in the following cycle with their key byte.
  always_comb begin
    q_push = 1'b0;
    q_item = '0;
    if (pend_r) begin
      q_push         = 1'b1;
      q_item.is_cipher = 1'b1;
      q_item.val     = msg_r;
      q_item.kb      = key_rd_r;
    end else if (accept && is_alpha) begin
      q_push         = 1'b1;
      q_item.idx     = idx;
      q_item.val     = val;
    end
  end

endmodule

// ===== rtl/core/vbc_back.sv =====
// Back end: alphabet store, match scan, index arithmetic and result register.
module vbc_back #(
  parameter int ALPHABET_DEPTH = vbc_pkg::ALPHABET_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mode,
  input  logic [5:0]         alen,
  input  logic               q_valid,
  input  vbc_pkg::vbc_item_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               out_flag
);
  import vbc_pkg::*;

  localparam int AW  = (ALPHABET_DEPTH > 2) ? $clog2(ALPHABET_DEPTH) : 1;
  localparam int ACW = (AW > 6) ? AW : 6;

  vbc_bk_state_t state_r, state_nxt;
  vbc_bk_ctl_t   ctl;

  logic [7:0]  lane_r [ALPHABET_DEPTH];
  logic [7:0]  amem   [ALPHABET_DEPTH];
  logic [ALPHABET_DEPTH-1:0] aval_r;

  logic [ALPHABET_DEPTH-1:0] mx_c, my_c, mx_r, my_r;
  logic [AW-1:0] alen_eff;
  logic [AW-1:0] stop_c, stop_r;
  logic          found_c, found_r;
  logic [AW-1:0] x_c, y_c, x_r, y_r;
  logic [AW-1:0] sum_c;
  logic [7:0]    msg_r;
  logic [7:0]    rdata_r;
  logic          rvalid_r;
  logic [AW-1:0] raddr_r;
  logic [WIDE_IDX_W-1:0] idx_w;
  logic          wr_hit;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_flag_r;
  logic          out_free;

  assign idx_w    = WIDE_IDX_W'(q_head.idx);
  assign wr_hit   = idx_w < WIDE_IDX_W'(ALPHABET_DEPTH);
  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = ctl.pop;

  always_comb begin
    logic [ACW-1:0] a;
    a = ACW'(alen);
    if (a > ACW'(ALPHABET_DEPTH - 1)) alen_eff = AW'(ALPHABET_DEPTH - 1);
    else                              alen_eff = a[AW-1:0];
  end

  // Two comparators per lane, one for each byte, masked by the active length.
  always_comb begin
    for (int i = 0; i < ALPHABET_DEPTH; i++) begin
      mx_c[i] = (lane_r[i] == q_head.val) && (AW'(i) < alen_eff);
      my_c[i] = (lane_r[i] == q_head.kb)  && (AW'(i) < alen_eff);
    end
  end

  // First hit of each byte; the scan stops at the later of the two.
  always_comb begin
    logic [AW-1:0] fx, fy;
    fx = '0;
    fy = '0;
    for (int i = ALPHABET_DEPTH - 1; i >= 0; i--) begin
      if (mx_r[i]) fx = AW'(i);
      if (my_r[i]) fy = AW'(i);
    end
    found_c = (|mx_r) && (|my_r);
    stop_c  = (fx > fy) ? fx : fy;
  end

  // Last hit of each byte at or below the stop index.
  always_comb begin
    x_c = '0;
    y_c = '0;
    for (int i = 0; i < ALPHABET_DEPTH; i++) begin
      if (mx_r[i] && (AW'(i) <= stop_r)) x_c = AW'(i);
      if (my_r[i] && (AW'(i) <= stop_r)) y_c = AW'(i);
    end
  end

  always_comb begin
    logic [AW:0] s;
    if (mode) s = {1'b0, x_r} + {1'b0, alen_eff} - {1'b0, y_r};
    else      s = {1'b0, x_r} + {1'b0, y_r};
    if (s >= {1'b0, alen_eff}) s = s - {1'b0, alen_eff};
    sum_c = s[AW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (q_valid && q_head.is_cipher) state_nxt = BK_SCAN;
      BK_SCAN: state_nxt = found_c ? BK_PICK : BK_SEND;
      BK_PICK: state_nxt = BK_LOOK;
      BK_LOOK: state_nxt = BK_SEND;
      BK_SEND: if (out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      BK_IDLE: begin
        ctl.pop      = q_valid;
        ctl.wr_en    = q_valid && !q_head.is_cipher && wr_hit;
        ctl.ld_match = q_valid && q_head.is_cipher;
      end
      BK_SCAN: ctl.ld_scan = 1'b1;
      BK_PICK: ctl.ld_pick = 1'b1;
      BK_LOOK: ctl.rd_en   = 1'b1;
      BK_SEND: ctl.ld_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET_DEPTH; i++) begin
        lane_r[i] <= reset_letter(8'(i));
      end
    end else if (ctl.wr_en) begin
      lane_r[idx_w[AW-1:0]] <= q_head.val;
    end
  end

  // Lookup copy of the alphabet; unwritten entries read as their reset value.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      amem[idx_w[AW-1:0]] <= q_head.val;
    end
    if (ctl.rd_en) begin
      rdata_r <= amem[sum_c];
      raddr_r <= sum_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aval_r   <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) aval_r[idx_w[AW-1:0]] <= 1'b1;
      if (ctl.rd_en) rvalid_r <= aval_r[sum_c];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_match) begin
      mx_r  <= mx_c;
      my_r  <= my_c;
      msg_r <= q_head.val;
    end
    if (ctl.ld_scan) begin
      stop_r  <= stop_c;
      found_r <= found_c;
    end
    if (ctl.ld_pick) begin
      x_r <= x_c;
      y_r <= y_c;
    end
    if (ctl.ld_out) begin
      out_flag_r <= !found_r;
      if (!found_r)      out_byte_r <= msg_r;
      else if (rvalid_r) out_byte_r <= rdata_r;
      else               out_byte_r <= reset_letter(8'(raddr_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.ld_out)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_flag  = out_flag_r;

endmodule

// ===== rtl/core/vigenere_byte_cipher.sv =====
// Top level of the Vigenere byte cipher: ports, register bank, front/queue/back.
//
// Input stream (in_*): each transaction is an alphabet write, a key write or a
// message byte to cipher, selected by in_tuser[1:0]. Only cipher transactions
// produce a result on the output stream (out_*); writes and the unused op code
// produce none. Results come out in input order.
// Config port (cfg_*): cfg_ready is always high; writes take effect next cycle
// and must only be issued while the block has nothing in flight.
// A cipher byte is registered in the front end with its key byte, queued, then
// taken through the back end's sequence: match capture, first-hit scan, last-hit
// pick, modulo add and lookup read, result load; pass-through skips pick and read.
// The front end takes one write per cycle while the queue has room and holds off
// input while a cipher byte waits for its key byte; the back end retires one
// alphabet write per cycle while idle, one cipher byte at a time. A 4-deep queue
// lets the front keep accepting while the back works.
// Reset (rst_n low, synchronous): alphabet returns to A..Z, key position to zero,
// registers to encrypt / length 26 / key length 1; key contents are undefined.
// Receiver stall: the result register holds; the back end waits, the queue fills
// and then in_tready drops.
module vigenere_byte_cipher #(
  parameter int ALPHABET_DEPTH = vbc_pkg::ALPHABET_DEPTH_DEF,
  parameter int KEY_DEPTH      = vbc_pkg::KEY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] index, [13:6] value, [15:14] zero
  input  logic [2:0]  in_tuser,   // [1:0] op, [2] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] passed_through
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  import vbc_pkg::*;

  logic       mode_r;
  logic [5:0] alen_r;
  logic [6:0] klen_r;

  logic       q_push, q_full, q_pop, q_valid;
  vbc_item_t  q_item, q_head;

  assign cfg_ready = 1'b1;

  // Register bank; a zero key length is ignored, unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      alen_r <= 6'd26;
      klen_r <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_data[0];
        CFG_ALEN: alen_r <= cfg_data[5:0];
        CFG_KLEN: if (cfg_data != 7'd0) klen_r <= cfg_data;
        default:  ;
      endcase
    end
  end

  vbc_front #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .op       (vbc_op_t'(in_tuser[1:0])),
    .idx      (in_tdata[5:0]),
    .val      (in_tdata[13:6]),
    .restart  (in_tuser[2]),
    .klen     (klen_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  vbc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  vbc_back #(
    .ALPHABET_DEPTH (ALPHABET_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .alen      (alen_r),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_flag  (out_tuser)
  );

endmodule

// ===== rtl/core/vbc_checker.sv =====
// Port-level checker of the byte cipher, bound to the top level.
`include "vigenere_byte_cipher_assert.svh"

module vbc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [2:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser,
  input logic        cfg_ready
);
  import vbc_pkg::*;

  logic cipher_acc;
  logic result_stall;

  assign cipher_acc   = in_tvalid && in_tready && (in_tuser[1:0] == OP_CIPHER);
  assign result_stall = out_tvalid && !out_tready;

  // A stalled result keeps its payload.
  `VBC_ASSERT_NEXT(a_out_hold, clk, rst_n, result_stall,
                   out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Config writes are never back-pressured.
  `VBC_ASSERT_NOW(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

  // The front end holds off input the cycle after a cipher byte, while it fetches the key byte.
  `VBC_ASSERT_NEXT(a_key_fetch, clk, rst_n, cipher_acc, !in_tready)

  // Handshake outputs are never unknown once out of reset.
  `VBC_ASSERT_NOW(a_ctl_known, clk, rst_n, 1'b1, !$isunknown({in_tready, out_tvalid}))

endmodule

bind vigenere_byte_cipher vbc_checker u_vbc_checker (.*);

// ===== bench/vbc_result_checker.sv =====
// Result checker for the Vigenere byte cipher: predicts each result and compares it.
`timescale 1ns / 100ps

module vbc_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          mismatches,
  output int          pending
);

  import vbc_pkg::*;

  localparam int ALPHA_SLOTS = ALPHABET_DEPTH_DEF;
  localparam int KEY_SLOTS   = KEY_DEPTH_DEF;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [7:0] octet;
    logic       passed;
  } cipher_result_t;

  // Shadow copy of the block's state and registers.
  logic [7:0]     alpha_tbl [ALPHA_SLOTS];
  logic [7:0]     key_tbl   [KEY_SLOTS];
  int unsigned    key_pos;
  logic           decrypt;
  int unsigned    alpha_len;
  int unsigned    key_len;
  cipher_result_t cipher_q [$];

  task automatic clear_state();
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      alpha_tbl[i] = (i < RESET_LETTERS) ? LETTER_A + 8'(i) : 8'h00;
    end
    for (int i = 0; i < KEY_SLOTS; i++) key_tbl[i] = 8'h00;
    key_pos   = 0;
    decrypt   = 1'b0;
    alpha_len = 26;
    key_len   = 1;
    cipher_q.delete();
  endtask

  // Advances the key position and works out one ciphered byte.
  function automatic cipher_result_t encipher(input logic [7:0] msg, input logic restart);
    int unsigned    klen, alen, x, y, s;
    bit             fx, fy;
    logic [7:0]     kb;
    cipher_result_t r;
    klen = (key_len > KEY_SLOTS) ? KEY_SLOTS : key_len;
    if (restart || key_pos >= klen) key_pos = 0;
    kb = key_tbl[key_pos];
    key_pos++;
    if (key_pos >= klen) key_pos = 0;
    alen = (alpha_len > ALPHA_SLOTS - 1) ? ALPHA_SLOTS - 1 : alpha_len;
    x = 0; y = 0; fx = 0; fy = 0;
    // scan stops at the first index where both bytes have been seen
    for (int unsigned i = 0; i < alen && !(fx && fy); i++) begin
      if (alpha_tbl[i] == msg) begin x = i; fx = 1; end
      if (alpha_tbl[i] == kb) begin y = i; fy = 1; end
    end
    if (fx && fy) begin
      s = decrypt ? x + alen - y : x + y;
      if (s >= alen) s -= alen;
      r.octet  = alpha_tbl[s];
      r.passed = 1'b0;
    end else begin
      r.octet  = msg;
      r.passed = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    cipher_result_t want, got;
    logic [1:0]     op;
    logic [5:0]     idx;
    logic [7:0]     val;
    if (!rst_n) begin
      clear_state();
      mismatches <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE: decrypt = cfg_data[0];
          CFG_ALEN: alpha_len = cfg_data[5:0];
          CFG_KLEN: if (cfg_data != 7'd0) key_len = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.octet  = out_tdata;
        got.passed = out_tuser;
        if (cipher_q.size() == 0) begin
          if (mismatches < REPORT_MAX)
            $display("%0t: result with nothing expected: byte %h flag %b",
                     $realtime, got.octet, got.passed);
          mismatches <= mismatches + 1;
        end else begin
          want = cipher_q.pop_front();
          if (got.octet !== want.octet || got.passed !== want.passed) begin
            if (mismatches < REPORT_MAX)
              $display("%0t: mismatch: expected byte %h flag %b, got byte %h flag %b",
                       $realtime, want.octet, want.passed, got.octet, got.passed);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        op  = in_tuser[1:0];
        idx = in_tdata[5:0];
        val = in_tdata[13:6];
        case (op)
          OP_ALPHA:  alpha_tbl[idx] = val;
          OP_KEY:    key_tbl[idx] = val;
          OP_CIPHER: cipher_q.push_back(encipher(val, in_tuser[2]));
          default: ;
        endcase
      end
    end
    pending <= cipher_q.size();
  end

endmodule

// ===== bench/tb.sv =====
// Top of the Vigenere byte cipher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

  import vbc_pkg::*;

  // Op code and register index that the block has no use for
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  localparam int SETTLE_CYCLES = 40;    // back end drains queued writes well within this
  localparam int LONG_HOLD     = 300;   // receiver hold-off that fills the input queue
  localparam int IDLE_LIMIT    = 3000;  // watchdog: cycles with no transaction at all
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 140;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // [5:0] index, [13:6] value, [15:14] zero
  logic [2:0]  in_tuser   = '0;   // [1:0] op, [2] restart
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] out_byte
  logic        out_tuser;         // [0] passed_through
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [6:0]  cfg_data   = '0;

  int mismatches;
  int pending;

  // Knobs shared by the stimulus and the receiver
  int tx_gap_pct  = 0;
  int rx_stall_pct = 0;
  bit rx_hold_req = 0;

  // What the stimulus knows of the block, used only to shape the items
  logic [7:0] alpha_shadow [64];
  bit         key_done     [64];
  int         cur_alen;
  int         cur_keff;

  always #10 clk = ~clk;

  vigenere_byte_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  vbc_result_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin : watchdog
    int idle;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  // out_tready gets exactly one assignment per edge.
  initial begin : receiver
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 0;
        wait_left = LONG_HOLD;
      end
      if (wait_left > 0) begin
        out_tready <= 1'b0;
        wait_left--;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        out_tready <= 1'b0;
        wait_left = pick_gap() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One input transaction; valid stays high afterwards so back-to-back items
  // never drop it within a step.
  task automatic send_item(input logic [1:0] op, input logic [5:0] idx,
                           input logic [7:0] val, input logic rs);
    int g;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      g = pick_gap();
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, val, idx};
    in_tuser  <= {rs, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_ALPHA) alpha_shadow[idx] = val;
    if (op == OP_KEY)   key_done[idx] = 1;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pauses until every result is back, then lets queued writes retire
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A byte from the live alphabet most of the time, so lookups mostly hit
  function automatic logic [7:0] likely_byte(input int hit_pct);
    if (cur_alen > 0 && $urandom_range(0, 99) < hit_pct)
      return alpha_shadow[$urandom_range(0, cur_alen - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_item();
    int         r;
    logic [5:0] idx;
    logic [7:0] val;
    logic       rs;
    r   = $urandom_range(0, 99);
    idx = 6'($urandom_range(0, 63));
    rs  = 1'($urandom_range(0, 1));
    if (r < 72) begin
      val = likely_byte(75);
      send_item(OP_CIPHER, idx, val, $urandom_range(0, 9) == 0);
    end else if (r < 82) begin
      // alphabet rewrite, mostly inside the scanned range; duplicates welcome
      if (cur_alen > 0 && $urandom_range(0, 9) < 7) idx = 6'($urandom_range(0, cur_alen - 1));
      val = $urandom_range(0, 1) ? alpha_shadow[$urandom_range(0, 63)]
                                 : 8'($urandom_range(0, 255));
      send_item(OP_ALPHA, idx, val, rs);
    end else if (r < 94) begin
      send_item(OP_KEY, idx, likely_byte(80), rs);
    end else begin
      send_item(OP_UNUSED, idx, 8'($urandom_range(0, 255)), rs);
    end
  endtask

  // New register setting, then the key entries it makes reachable and,
  // on request, a fresh alphabet.
  task automatic prep_phase(input logic m, input int a, input int k, input bit reload);
    logic [6:0] d;
    logic [7:0] val;
    settle();
    d    = 7'($urandom_range(0, 127));
    d[0] = m;
    write_reg(CFG_MODE, d);
    d = {1'($urandom_range(0, 1)), 6'(a)};
    write_reg(CFG_ALEN, d);
    write_reg(CFG_KLEN, 7'(k));
    cur_alen = a;
    if (k != 0) cur_keff = (k > 64) ? 64 : k;
    // never let a cipher read a key entry that was not written
    for (int i = 0; i < cur_keff; i++) begin
      if (!key_done[i]) send_item(OP_KEY, 6'(i), likely_byte(80), 1'($urandom_range(0, 1)));
    end
    if (reload) begin
      for (int i = 0; i < cur_alen; i++) begin
        if (i > 0 && $urandom_range(0, 9) == 0) val = alpha_shadow[$urandom_range(0, i - 1)];
        else val = 8'($urandom_range(0, 255));
        send_item(OP_ALPHA, 6'(i), val, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin : stimulus
    logic m;
    int   a, k;
    bit   reload;
    for (int i = 0; i < 64; i++) begin
      alpha_shadow[i] = (i < RESET_LETTERS) ? LETTER_A + 8'(i) : 8'h00;
      key_done[i]     = 0;
    end
    cur_alen = 26;
    cur_keff = 1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset settings first: encrypt, 26 letters, one key byte
    send_item(OP_KEY, 6'd0, 8'h43, 1'b0);          // key 'C'
    send_item(OP_KEY, 6'd63, 8'hFF, 1'b1);         // extreme index and value
    send_item(OP_CIPHER, 6'd0, 8'h41, 1'b1);       // 'A' -> 'C'
    send_item(OP_CIPHER, 6'd63, 8'h5A, 1'b0);      // 'Z' wraps -> 'B'
    send_item(OP_CIPHER, 6'd0, 8'h00, 1'b0);       // zero byte not in range: passes
    send_item(OP_CIPHER, 6'd0, 8'hFF, 1'b1);       // passes through
    send_item(OP_UNUSED, 6'd63, 8'hFF, 1'b1);      // no result
    send_item(OP_ALPHA, 6'd5, 8'h41, 1'b0);        // second 'A' replaces 'F'
    send_item(OP_CIPHER, 6'd0, 8'h41, 1'b0);       // scan stops before the later 'A'
    send_item(OP_KEY, 6'd0, 8'h48, 1'b0);          // key 'H'
    send_item(OP_CIPHER, 6'd0, 8'h41, 1'b0);       // later 'A' reached first: takes index 5
    send_item(OP_CIPHER, 6'd0, 8'h46, 1'b0);       // 'F' gone: passes
    send_item(OP_KEY, 6'd1, 8'h5A, 1'b0);

    // Decrypt, two key bytes; zero key length and the spare index are ignored
    settle();
    write_reg(CFG_MODE, 7'd1);
    write_reg(CFG_KLEN, 7'd2);
    write_reg(CFG_KLEN, 7'd0);
    write_reg(CFG_SPARE, 7'h7F);
    cur_keff = 2;
    send_item(OP_CIPHER, 6'd0, 8'h41, 1'b1);
    send_item(OP_CIPHER, 6'd0, 8'h42, 1'b0);       // key position wraps after this
    send_item(OP_CIPHER, 6'd0, 8'h43, 1'b0);       // position left at one

    // Shrinking the key leaves a stale position; empty alphabet passes all
    settle();
    write_reg(CFG_KLEN, 7'd1);
    write_reg(CFG_ALEN, 7'd0);
    cur_keff = 1;
    cur_alen = 0;
    send_item(OP_CIPHER, 6'd0, 8'h41, 1'b0);

    // Full scan length: zero entries past the letters are ordinary bytes
    settle();
    write_reg(CFG_ALEN, 7'd63);
    write_reg(CFG_MODE, 7'd0);
    cur_alen = 63;
    send_item(OP_CIPHER, 6'd0, 8'h00, 1'b0);
    send_item(OP_ALPHA, 6'd62, 8'hFF, 1'b0);
    send_item(OP_CIPHER, 6'd0, 8'hFF, 1'b0);

    // Random phases: the first four pin the register extremes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin m = 1'b0; a = 63; k = 127; reload = 0; end  // key length past depth
        1: begin m = 1'b1; a = 1;  k = 64;  reload = 1; end
        2: begin m = 1'b1; a = 63; k = 1;   reload = 1; end
        3: begin m = 1'b0; a = 0;  k = 5;   reload = 0; end
        default: begin
          m      = 1'($urandom_range(0, 1));
          a      = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 63);
          k      = $urandom_range(0, 127);
          reload = $urandom_range(0, 1);
        end
      endcase
      case (ph)
        2: begin tx_gap_pct = 0; rx_stall_pct = 30; end   // long hold-off below
        4: begin tx_gap_pct = 0; rx_stall_pct = 0;  end   // no idling at all
        default: begin
          tx_gap_pct   = $urandom_range(0, 2) * 20;
          rx_stall_pct = $urandom_range(0, 2) * 20;
        end
      endcase
      prep_phase(m, a, k, reload);
      if (ph == 2) rx_hold_req = 1;
      repeat (PHASE_ITEMS) random_item();
    end

    // Drain and give the back end time to show anything stray
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
